[rtl/core/rde_pkg.sv]
package rde_pkg;

	localparam int VALUE_BITS  = 31;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 7;
	localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
	localparam int SP_W        = $clog2(VALUE_BITS + 1);
	localparam int IDX_W       = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(55);

	typedef logic [DIGIT_W-1:0] digit_t;

	// Map a digit value to '0'-'9' then 'A'-'F'.
	function automatic logic [CHAR_W-1:0] glyph(input digit_t d);
		logic [CHAR_W-1:0] ext;
		ext = CHAR_W'(d);
		if (d < DIGIT_W'(10)) begin
			return CHAR_ZERO + ext;
		end
		return CHAR_LETTER + ext;
	endfunction

endpackage

[rtl/core/radix_digit_emitter.sv]
// Flow: every digit of a request is divided out and stacked before the first digit leaves,
//   most significant first; a new request is taken only once the previous one is fully popped.
// Division: the bit-serial divider yields one quotient bit per cycle and makes one full
//   pass over the dividend for each digit.
// Reset: arst_n clears control state and loads the radix register with 10; no
//   clearing pass is needed.
module radix_digit_emitter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rde_pkg::RADIX_W-1:0]          cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rde_pkg::VALUE_BITS-1:0]       value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rde_pkg::CHAR_W-1:0]           digit_char,
	output logic                                 last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [rde_pkg::BIT_CNT_W-1:0] LAST_BIT =
		rde_pkg::BIT_CNT_W'(rde_pkg::VALUE_BITS - 1);

	logic [1:0]                          state_q;
	logic [rde_pkg::RADIX_W-1:0]         radix_q;
	logic [rde_pkg::VALUE_BITS-1:0]      dvd_q;     // dividend, fills with quotient bits
	rde_pkg::digit_t                     rem_q;     // running remainder, always below base
	logic [rde_pkg::BIT_CNT_W-1:0]       bit_cnt_q;
	logic                                nz_q;      // any quotient bit set this pass
	logic [rde_pkg::SP_W-1:0]            sp_q;      // digits held on the stack
	rde_pkg::digit_t                     stack_q [rde_pkg::VALUE_BITS];
	logic                                out_valid_q;
	logic [rde_pkg::CHAR_W-1:0]          digit_char_q;
	logic                                last_q;

	logic [rde_pkg::RADIX_W-1:0]         base;
	logic [rde_pkg::RADIX_W-1:0]         trial;
	logic                                qbit;
	rde_pkg::digit_t                     rem_n;
	logic                                out_free;
	logic                                pop;
	logic [rde_pkg::SP_W-1:0]            sp_dec;

	// Saturate the radix register to the two-to-sixteen range.
	always_comb begin
		if (radix_q < rde_pkg::RADIX_MIN) begin
			base = rde_pkg::RADIX_MIN;
		end else if (radix_q > rde_pkg::RADIX_MAX) begin
			base = rde_pkg::RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	// One restoring-division step: bring down the next dividend bit and
	// subtract the base if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[rde_pkg::VALUE_BITS-1]};
		qbit  = (trial >= base);
		if (qbit) begin
			rem_n = rde_pkg::DIGIT_W'(trial - base);
		end else begin
			rem_n = trial[rde_pkg::DIGIT_W-1:0];
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == ST_EMIT) && out_free && (sp_q != '0);
	assign sp_dec   = sp_q - rde_pkg::SP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rde_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Control: accept, divide digit by digit, then drain the stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			nz_q      <= 1'b0;
			sp_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q   <= ST_DIV;
						bit_cnt_q <= '0;
						nz_q      <= 1'b0;
						sp_q      <= '0;
					end
				end
				ST_DIV: begin
					if (bit_cnt_q == LAST_BIT) begin
						// push the remainder; stop once the quotient is zero
						sp_q      <= sp_q + rde_pkg::SP_W'(1);
						bit_cnt_q <= '0;
						nz_q      <= 1'b0;
						if (!(nz_q || qbit)) begin
							state_q <= ST_EMIT;
						end
					end else begin
						bit_cnt_q <= bit_cnt_q + rde_pkg::BIT_CNT_W'(1);
						nz_q      <= nz_q || qbit;
					end
				end
				ST_EMIT: begin
					if (pop) begin
						sp_q <= sp_dec;
					end else if (sp_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: dividend shifts left one bit a cycle, quotient enters at the bottom.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dvd_q <= value;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[rde_pkg::VALUE_BITS-2:0], qbit};
			if (bit_cnt_q == LAST_BIT) begin
				rem_q <= '0;
			end else begin
				rem_q <= rem_n;
			end
		end
	end

	// Digit stack: written least significant first, read back in reverse.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && (bit_cnt_q == LAST_BIT)) begin
			stack_q[sp_q[rde_pkg::IDX_W-1:0]] <= rem_n;
		end
	end

	// Output register: load on pop, drop valid once the digit is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			digit_char_q <= rde_pkg::glyph(stack_q[sp_dec[rde_pkg::IDX_W-1:0]]);
			last_q       <= (sp_q == rde_pkg::SP_W'(1));
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (sp_q == '0))
		else $error("stack not empty while idle");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= rde_pkg::SP_W'(rde_pkg::VALUE_BITS))
		else $error("digit stack overflow");

	a_more_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> (state_q == ST_EMIT))
		else $error("digits missing after a non-final digit");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
			(digit_char >= 7'd65 && digit_char <= 7'd70)))
		else $error("digit character out of range");

endmodule

[dv/testbench.sv]
module testbench;

	typedef logic [rde_pkg::VALUE_BITS-1:0] value_t;

	// Expected digit stream for every accepted request, oldest first.
	class digit_scoreboard;
		typedef struct packed {
			logic [rde_pkg::CHAR_W-1:0] ch;
			logic                       fin;
		} digit_exp_t;

		digit_exp_t                  expected_digits[$];
		logic [rde_pkg::RADIX_W-1:0] radix_reg;
		string                       glyphs;
		int                          errors;
		int                          digits_seen;

		function new();
			radix_reg   = rde_pkg::RADIX_RESET;
			glyphs      = "0123456789ABCDEF";
			errors      = 0;
			digits_seen = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Convert one request into its digits, most significant first.
		function void note_request(input value_t v);
			logic [rde_pkg::RADIX_W-1:0] base;
			value_t                      rest;
			logic [3:0]                  lsd_first[$];
			digit_exp_t                  e;
			int                          k;
			base = radix_reg;
			if (base < rde_pkg::RADIX_MIN) begin
				base = rde_pkg::RADIX_MIN;
			end else if (base > rde_pkg::RADIX_MAX) begin
				base = rde_pkg::RADIX_MAX;
			end
			rest = v;
			do begin
				lsd_first.push_back(4'(rest % base));
				rest = rest / base;
			end while (rest != 0);
			for (k = lsd_first.size() - 1; k >= 0; k--) begin
				e.ch  = rde_pkg::CHAR_W'(glyphs[lsd_first[k]]);
				e.fin = (k == 0);
				expected_digits.push_back(e);
			end
		endfunction

		task check_digit(input logic [rde_pkg::CHAR_W-1:0] ch, input logic fin);
			digit_exp_t e;
			digits_seen++;
			if (expected_digits.size() == 0) begin
				report($sformatf("digit 0x%0h last=%0b with nothing expected", ch, fin));
				return;
			end
			e = expected_digits.pop_front();
			if (ch !== e.ch)
				report($sformatf("digit_char 0x%0h, expected 0x%0h", ch, e.ch));
			if (fin !== e.fin)
				report($sformatf("last %0b, expected %0b (digit 0x%0h)", fin, e.fin, e.ch));
		endtask

		function int pending();
			return expected_digits.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [rde_pkg::RADIX_W-1:0] cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	value_t                      value;
	logic                        out_valid;
	logic                        out_ready;
	logic [rde_pkg::CHAR_W-1:0]  digit_char;
	logic                        last;

	digit_scoreboard sb = new();

	// Longest idle gap each side may draw; zero gives back-to-back stretches.
	int src_gap_max  = 12;
	int sink_gap_max = 12;

	radix_digit_emitter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last)
	);

	always #4 clk = ~clk;

	// Offer one request after a random gap and hold it until the block takes it.
	// Keep valid high across back-to-back requests; lower it only when a gap is drawn.
	task automatic send_value(input value_t v);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(v);
	endtask

	// Drop valid and wait until every expected digit has come back.
	// Always advance at least one edge so valid is never lowered and raised in one step.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Write the radix register while the block is idle.
	task automatic set_radix(input logic [rde_pkg::RADIX_W-1:0] r);
		drain();
		cfg_wdata <= r;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we       <= 1'b0;
		sb.radix_reg  = r;
	endtask

	// Mostly short values, some of random width, a few at the full width.
	function automatic value_t draw_value();
		int w;
		case ($urandom_range(0, 7))
			0, 1, 2: return value_t'($urandom_range(0, 255));
			3, 4, 5: begin
				w = $urandom_range(1, rde_pkg::VALUE_BITS);
				return value_t'($urandom) >> (rde_pkg::VALUE_BITS - w);
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	// Mostly legal bases, sometimes any register value to hit the saturation.
	function automatic logic [rde_pkg::RADIX_W-1:0] draw_radix();
		if ($urandom_range(0, 3) == 0)
			return rde_pkg::RADIX_W'($urandom_range(0, 31));
		return rde_pkg::RADIX_W'($urandom_range(2, 16));
	endfunction

	// Stimulus: reset, directed requests, then random phases with a radix each.
	initial begin
		int ph;
		int n;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		value     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset radix of ten, left unwritten: zero, one, the nine/ten and
		// ninety-nine/hundred carries, the largest value, and one billion.
		send_value(value_t'(0));
		send_value(value_t'(1));
		send_value(value_t'(9));
		send_value(value_t'(10));
		send_value(value_t'(99));
		send_value(value_t'(100));
		send_value('1);
		send_value(value_t'(1000000000));

		// Base two: longest digit strings, including the full-width maximum.
		set_radix(rde_pkg::RADIX_W'(2));
		send_value(value_t'(0));
		send_value(value_t'(1));
		send_value('1);
		send_value(value_t'(1) << (rde_pkg::VALUE_BITS - 1));
		send_value(value_t'(32'h5555_5555));

		// Base sixteen: every letter digit.
		set_radix(rde_pkg::RADIX_W'(16));
		send_value(value_t'(32'h0FED_CBA9));
		send_value('1);
		send_value(value_t'(15));
		send_value(value_t'(0));

		// Register values below two clamp to two, above sixteen clamp to sixteen; then base three.
		set_radix(rde_pkg::RADIX_W'(0));
		send_value(value_t'(5));
		set_radix(rde_pkg::RADIX_W'(1));
		send_value(value_t'(6));
		set_radix(rde_pkg::RADIX_W'(17));
		send_value(value_t'(255));
		set_radix(rde_pkg::RADIX_W'(31));
		send_value('1);
		set_radix(rde_pkg::RADIX_W'(3));
		send_value('1);

		// Random phases; every third one runs the sender without gaps.
		for (ph = 0; ph < 8; ph++) begin
			set_radix(draw_radix());
			src_gap_max = (ph % 3 == 1) ? 0 : 12;
			for (n = 0; n < 50; n++) begin
				// Pause mid-phase until the block has emptied.
				if (ph == 4 && n == 25)
					drain();
				send_value(draw_value());
			end
		end

		drain();
		repeat (1100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("** radix_digit_emitter: PASSED **");
		end else begin
			$display("** radix_digit_emitter: FAILED **");
		end
		$finish;
	end

	// Digit sink: random backpressure, stretches without any, and a long
	// hold-off now and then so the block fills up and stalls its input.
	initial begin
		int gap;
		int next_hold;
		int next_mode;
		next_hold = 350;
		next_mode = 100;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sb.digits_seen >= next_mode) begin
				sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
				next_mode += 100;
			end
			if (sb.digits_seen >= next_hold) begin
				gap = 500;
				next_hold += 700;
			end else begin
				gap = $urandom_range(0, sink_gap_max);
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_digit(digit_char, last);
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#24000000;
		$display("** radix_digit_emitter: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/rde_pkg.sv
rtl/core/radix_digit_emitter.sv
dv/testbench.sv
